// File: sv/sal_pkg.sv
// Shared types and constants for the shifting array list.
package sal_pkg;

   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int TGT_W    = 5;
   localparam int STATUS_W = 2;
   localparam int PLACED_W = 4;
   localparam int COUNT_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND       = 3'd0,
      OP_REMOVE_LAST  = 3'd1,
      OP_INSERT_FRONT = 3'd2,
      OP_REMOVE_FRONT = 3'd3,
      OP_INSERT_AT    = 3'd4,
      OP_REMOVE_AT    = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_POS   = 2'd3
   } status_type;

   typedef struct packed {
      logic shift_up;
      logic shift_down;
   } cell_ctrl_type;

endpackage

// File: sv/shifting_array_list.sv
// Top level of the shifting array list: request decode, count and result register.
//
// An ordered list of up to CAPACITY signed 32-bit words held in a row of cells.
// A request transfer on the req_ channel carries an operation, a data word and
// a target position. On every insert or removal each cell compares its own
// index with the position and takes its lower neighbor, its upper neighbor or
// the new word, so all later entries move at once.
// One result transfer on the rsp_ channel follows every request. The result is
// registered and valid in the cycle after the request transfer; one request is
// taken per cycle as long as the receiver keeps rsp_ready high.
// When a result waits and rsp_ready is low, req_ready drops and the list holds
// still until the result transfer completes, so nothing is lost.
// Full, empty and bad-position requests leave the list unchanged and report a
// status. Reset empties the list at once; the cell contents are not cleared
// and are never read before they are written.
module shifting_array_list #(
   parameter int CAPACITY = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sal_pkg::OP_W-1:0]        req_operation,
   input  logic signed [sal_pkg::DATA_W-1:0] req_item_value,
   input  logic [sal_pkg::TGT_W-1:0]       req_target_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sal_pkg::STATUS_W-1:0]    rsp_status,
   output logic signed [sal_pkg::DATA_W-1:0] rsp_removed_value,
   output logic [sal_pkg::PLACED_W-1:0]    rsp_placed_index,
   output logic [sal_pkg::COUNT_W-1:0]     rsp_entry_count,
   output logic                            rsp_is_full,
   output logic                            rsp_is_empty
);
   import sal_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int WIDE_W = (CNT_W > TGT_W) ? CNT_W : TGT_W;

   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    count_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [STATUS_W-1:0] status_in;
   logic [DATA_W-1:0]   removed_ff;
   logic [DATA_W-1:0]   removed_in;
   logic [PLACED_W-1:0] placed_ff;
   logic [PLACED_W-1:0] placed_in;
   logic [COUNT_W-1:0]  entry_count_ff;
   logic [COUNT_W-1:0]  entry_count_in;
   logic                full_ff;
   logic                full_in;
   logic                empty_ff;
   logic                empty_in;

   logic                accept;
   logic                is_full;
   logic                is_empty;
   logic                insert_ok;
   logic                remove_ok;
   logic [WIDE_W-1:0]   count_w;
   logic [WIDE_W-1:0]   tgt_w;
   logic [WIDE_W-1:0]   pos_w;
   logic [IDX_W-1:0]    pos;
   cell_ctrl_type       ctrl;
   status_type          status;
   logic [DATA_W-1:0]   cell_data [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(CAPACITY));
   assign is_empty  = (count_ff == '0);
   assign count_w   = WIDE_W'(count_ff);
   assign tgt_w     = WIDE_W'(req_target_index);

   always_comb begin
      status    = ST_OK;
      insert_ok = 1'b0;
      remove_ok = 1'b0;
      pos_w     = '0;
      case (op_type'(req_operation))
         OP_APPEND, OP_INSERT_FRONT, OP_INSERT_AT: begin
            if (op_type'(req_operation) == OP_APPEND) begin
               pos_w = count_w;
            end else if (op_type'(req_operation) == OP_INSERT_AT) begin
               pos_w = tgt_w;
            end
            if (is_full) begin
               status = ST_FULL;
            end else if (pos_w > count_w) begin
               status = ST_POS;
            end else begin
               insert_ok = 1'b1;
            end
         end
         OP_REMOVE_LAST, OP_REMOVE_FRONT: begin
            if (op_type'(req_operation) == OP_REMOVE_LAST) begin
               pos_w = count_w - WIDE_W'(1);
            end
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               remove_ok = 1'b1;
            end
         end
         OP_REMOVE_AT: begin
            pos_w = tgt_w;
            if (tgt_w >= count_w) begin
               status = ST_POS;
            end else begin
               remove_ok = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   assign pos             = pos_w[IDX_W-1:0];
   assign ctrl.shift_up   = accept && insert_ok;
   assign ctrl.shift_down = accept && remove_ok;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] lower;
      logic [DATA_W-1:0] upper;
      if (i == 0) begin : g_first
         assign lower = cell_data[i];
      end else begin : g_lower
         assign lower = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign upper = cell_data[i];
      end else begin : g_upper
         assign upper = cell_data[i+1];
      end
      sal_cell #(
         .INDEX (i),
         .POS_W (IDX_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (pos),
         .new_value  (req_item_value),
         .lower_data (lower),
         .upper_data (upper),
         .data       (cell_data[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.shift_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      status_in      = status_ff;
      removed_in     = removed_ff;
      placed_in      = placed_ff;
      entry_count_in = entry_count_ff;
      full_in        = full_ff;
      empty_in       = empty_ff;
      if (accept) begin
         rsp_valid_in   = 1'b1;
         status_in      = status;
         removed_in     = remove_ok ? cell_data[pos] : '0;
         placed_in      = insert_ok ? pos_w[PLACED_W-1:0] : '0;
         entry_count_in = COUNT_W'(count_in);
         full_in        = (count_in == CNT_W'(CAPACITY));
         empty_in       = (count_in == '0);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff      <= status_in;
      removed_ff     <= removed_in;
      placed_ff      <= placed_in;
      entry_count_ff <= entry_count_in;
      full_ff        <= full_in;
      empty_ff       <= empty_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_placed_index  = placed_ff;
   assign rsp_entry_count   = entry_count_ff;
   assign rsp_is_full       = full_ff;
   assign rsp_is_empty      = empty_ff;

endmodule

// File: sv/sal_cell.sv
// One storage cell of the list that takes a word from a neighbor or the new word on a shift.
module sal_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 4
) (
   input  logic                          clock,
   input  sal_pkg::cell_ctrl_type        ctrl,
   input  logic [POS_W-1:0]              pos,
   input  logic [sal_pkg::DATA_W-1:0]    new_value,
   input  logic [sal_pkg::DATA_W-1:0]    lower_data,
   input  logic [sal_pkg::DATA_W-1:0]    upper_data,
   output logic [sal_pkg::DATA_W-1:0]    data
);
   import sal_pkg::*;

   localparam logic [POS_W-1:0] MY_INDEX = POS_W'(INDEX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift_up) begin
         if (MY_INDEX > pos) begin
            data_in = lower_data;
         end else if (MY_INDEX == pos) begin
            data_in = new_value;
         end
      end else if (ctrl.shift_down) begin
         if (MY_INDEX >= pos) begin
            data_in = upper_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule
